@@ hw/rtl/ccns_pkg.sv @@
// ----------------------------------------------------------------------------
// ccns_pkg
// Types and constants shared by the clause normalize and split unit.
// ----------------------------------------------------------------------------
package ccns_pkg;

    localparam int MaxVars = 4096;
    localparam int MaxClauseLits = 8;
    localparam int SplitWidth = 3;
    localparam int LitW = 21;
    localparam int LenW = $clog2(MaxClauseLits + 1);
    localparam int IdxW = $clog2(MaxClauseLits);
    localparam logic [LitW-1:0] LitMax = 21'h0FFFFF;

    localparam logic CFG_DECLARED_VARS = 1'b0;
    localparam logic CFG_SPLIT = 1'b1;

    typedef struct packed {
        logic signed [13:0] literal;
        logic               last_in_clause;
    } in_word_t;

    typedef struct packed {
        logic signed [20:0] out_literal;
        logic               clause_end;
        logic               is_added_clause;
        logic               error;
        logic [31:0]        duplicate_count;
        logic [31:0]        tautology_count;
        logic [31:0]        unit_count;
        logic [3:0]         longest_clause;
        logic [19:0]        fresh_var_count;
        logic [31:0]        added_clause_count;
    } out_word_t;

    // Seven words of one cut: (-b,d), (-a,d), (a,b,-d).
    typedef enum logic [2:0] {
        PH_NEG_B, PH_D_FIRST, PH_NEG_A, PH_D_SECOND, PH_A, PH_B, PH_NEG_D
    } ph_t;

    typedef enum logic [1:0] { EM_IDLE, EM_BODY, EM_ERR } em_t;

    // One control word for the cell row.
    typedef struct packed {
        logic            load;
        logic            shift;
        logic            clear;
        logic signed [LitW-1:0] lit;
    } cell_ctl_t;

endpackage

@@ hw/rtl/ccns_cell.sv @@
// ----------------------------------------------------------------------------
// ccns_cell
// One literal slot of the clause row; loads where addressed, shifts toward head.
// ----------------------------------------------------------------------------
module ccns_cell import ccns_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cell_ctl_t              ctl,
    input  logic                   load_here,
    input  logic                   prev_valid,
    input  logic signed [LitW-1:0] prev_lit,
    output logic                   valid,
    output logic signed [LitW-1:0] lit
);
    logic valid_reg, valid_next;
    logic signed [LitW-1:0] lit_reg, lit_next;

    always_comb
    begin
        valid_next = valid_reg;
        lit_next = lit_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            valid_next = prev_valid;
            lit_next = prev_lit;
        end
        else if (ctl.load && load_here)
        begin
            valid_next = 1'b1;
            lit_next = ctl.lit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lit_reg <= lit_next;
    end

    assign valid = valid_reg;
    assign lit = lit_reg;
endmodule

@@ hw/rtl/cnf_clause_normalize_split_unit.sv @@
// ----------------------------------------------------------------------------
// cnf_clause_normalize_split_unit
// Removes repeated literals, drops tautologies and, in split mode, cuts clauses to 3-CNF.
// ----------------------------------------------------------------------------
// Channel   Direction  Word
// in        input      in_word_t  (literal, last_in_clause)
// out       output     out_word_t (literal, flags, statistics)
// cfg       input      write enable, 1-bit index, 13-bit data
// A literal is compared against every held cell when it is taken.
// At a clause end the input stalls while its words leave: one for an error,
// seven for each cut, then one per kept literal, one word per cycle unless
// the output stalls. A tautology ends its clause with no word and no stall.
// Reset clears the cell row, the counters and the output register.
module cnf_clause_normalize_split_unit import ccns_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  in_word_t    in_data,
    input  logic        in_valid,
    output logic        in_stall,
    output out_word_t   out_data,
    output logic        out_valid,
    input  logic        out_stall,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);
    logic [12:0] dv_reg, dv_next;
    logic split_reg, split_next;
    logic [LenW-1:0] len_reg, len_next;
    logic sat_reg, sat_next;
    logic bad_reg, bad_next;
    logic [31:0] dup_reg, dup_next;
    logic [31:0] taut_reg, taut_next;
    logic [31:0] unit_reg, unit_next;
    logic [31:0] add_reg, add_next;
    logic [3:0] maxl_reg, maxl_next;
    logic [19:0] fresh_reg, fresh_next;
    em_t em_reg, em_next;
    ph_t ph_reg, ph_next;
    logic [LenW-1:0] n_reg, n_next;
    logic [LenW-1:0] cuts_reg, cuts_next;
    logic signed [LitW-1:0] d_reg, d_next;
    out_word_t ow_reg, ow_next;
    logic ow_valid_reg, ow_valid_next;

    cell_ctl_t ctl;
    logic [LenW-1:0] ld_idx;
    logic [MaxClauseLits-1:0] cv;
    logic signed [LitW-1:0] cl [MaxClauseLits];

    function automatic logic [31:0] sinc(input logic [31:0] v, input logic [1:0] by);
        logic [32:0] s;
        s = {1'b0, v} + 33'(by);
        return s[32] ? 32'hFFFFFFFF : s[31:0];
    endfunction

    function automatic logic [31:0] add_sat(input logic [31:0] v, input logic [LenW-1:0] c);
        logic [34:0] s;
        s = {3'b0, v} + 35'(c) * 35'd3;
        return (s > 35'h0FFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
    endfunction

    genvar g;
    generate
        for (g = 0; g < MaxClauseLits; g++)
        begin : g_row
            logic nb_valid;
            logic signed [LitW-1:0] nb_lit;
            if (g == MaxClauseLits - 1)
            begin : g_tail
                assign nb_valid = 1'b0;
                assign nb_lit = '0;
            end
            else
            begin : g_mid
                assign nb_valid = cv[g+1];
                assign nb_lit = cl[g+1];
            end
            ccns_cell u_cell (
                .clk(clk), .rst_n(rst_n), .ctl(ctl),
                .load_here(ld_idx == LenW'(g)),
                .prev_valid(nb_valid), .prev_lit(nb_lit),
                .valid(cv[g]), .lit(cl[g])
            );
        end
    endgenerate

    logic signed [LitW-1:0] lit_x;
    logic [13:0] var_x;
    logic hit_pos, hit_neg, lit_bad, take, emit_ok;
    logic step_bad, step_dup, step_sat, newlit, bad_n, sat_n;
    logic [LenW-1:0] nlen, cuts_need;
    logic [LitW:0] fresh_sum;
    logic fresh_over;
    logic [IdxW-1:0] a_idx, b_idx;
    logic signed [LitW-1:0] a_lit, b_lit;

    assign lit_x = LitW'(in_data.literal);
    assign var_x = in_data.literal[13] ? 14'(-in_data.literal) : in_data.literal;
    assign lit_bad = (in_data.literal == 14'sd0) || (var_x > {1'b0, dv_reg})
                     || (var_x > 14'(MaxVars));

    always_comb
    begin
        hit_pos = 1'b0;
        hit_neg = 1'b0;
        for (int i = 0; i < MaxClauseLits; i++)
        begin
            if (cv[i] && cl[i] == lit_x) hit_pos = 1'b1;
            if (cv[i] && cl[i] == -lit_x) hit_neg = 1'b1;
        end
    end

    assign emit_ok = !ow_valid_reg || !out_stall;
    assign in_stall = (em_reg != EM_IDLE);
    assign take = in_valid && !in_stall;

    assign step_bad = !bad_reg && (lit_bad ||
                      (!hit_pos && !hit_neg && len_reg >= LenW'(MaxClauseLits)));
    assign step_dup = !bad_reg && !lit_bad && hit_pos;
    assign step_sat = !bad_reg && !lit_bad && !hit_pos && hit_neg;
    assign newlit = !bad_reg && !lit_bad && !hit_pos && !hit_neg
                    && (len_reg < LenW'(MaxClauseLits));
    assign bad_n = bad_reg || step_bad;
    assign sat_n = sat_reg || step_sat;
    assign nlen = newlit ? len_reg + LenW'(1) : len_reg;
    assign cuts_need = (split_reg && nlen > LenW'(SplitWidth)) ?
                       nlen - LenW'(SplitWidth) : '0;
    assign fresh_sum = (LitW+1)'(dv_reg) + (LitW+1)'(fresh_reg) + (LitW+1)'(cuts_need);
    assign fresh_over = fresh_sum > (LitW+1)'(LitMax);

    assign a_idx = IdxW'(n_reg - LenW'(2));
    assign b_idx = IdxW'(n_reg - LenW'(1));
    assign a_lit = cl[a_idx];
    assign b_lit = cl[b_idx];

    always_comb
    begin
        dv_next = dv_reg;
        split_next = split_reg;
        len_next = len_reg;
        sat_next = sat_reg;
        bad_next = bad_reg;
        dup_next = dup_reg;
        taut_next = taut_reg;
        unit_next = unit_reg;
        add_next = add_reg;
        maxl_next = maxl_reg;
        fresh_next = fresh_reg;
        em_next = em_reg;
        ph_next = ph_reg;
        n_next = n_reg;
        cuts_next = cuts_reg;
        d_next = d_reg;
        ow_next = ow_reg;
        ow_valid_next = ow_valid_reg;
        ctl = '0;
        ctl.lit = lit_x;
        ld_idx = len_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DECLARED_VARS: dv_next = cfg_data;
                CFG_SPLIT: split_next = cfg_data[0];
                default: ;
            endcase
        end

        if (ow_valid_reg && !out_stall)
        begin
            ow_valid_next = 1'b0;
        end

        if (take)
        begin
            bad_next = bad_n;
            sat_next = sat_n;
            len_next = nlen;
            ctl.load = newlit;
            if (step_dup)
            begin
                dup_next = sinc(dup_reg, 2'd1);
            end
            if (in_data.last_in_clause)
            begin
                if (bad_n || (!sat_n && nlen != '0 && fresh_over))
                begin
                    em_next = EM_ERR;
                end
                else if (sat_n || nlen == '0)
                begin
                    if (sat_n) taut_next = sinc(taut_reg, 2'd1);
                    len_next = '0;
                    sat_next = 1'b0;
                    bad_next = 1'b0;
                    ctl.clear = 1'b1;
                end
                else
                begin
                    em_next = EM_BODY;
                    n_next = nlen;
                    cuts_next = cuts_need;
                    ph_next = PH_NEG_B;
                    d_next = LitW'(dv_reg) + LitW'(fresh_reg) + LitW'(1);
                    if (4'(nlen) > maxl_reg) maxl_next = 4'(nlen);
                    if (nlen == LenW'(1)) unit_next = sinc(unit_reg, 2'd1);
                    fresh_next = fresh_reg + 20'(cuts_need);
                    add_next = add_sat(add_reg, cuts_need);
                end
            end
        end

        if (em_reg != EM_IDLE && emit_ok)
        begin
            ow_valid_next = 1'b1;
            ow_next.duplicate_count = dup_reg;
            ow_next.tautology_count = taut_reg;
            ow_next.unit_count = unit_reg;
            ow_next.longest_clause = maxl_reg;
            ow_next.fresh_var_count = fresh_reg;
            ow_next.added_clause_count = add_reg;
            ow_next.out_literal = '0;
            ow_next.clause_end = 1'b0;
            ow_next.is_added_clause = 1'b0;
            ow_next.error = 1'b0;
            case (em_reg)
                EM_ERR:
                begin
                    ow_next.error = 1'b1;
                    ow_next.clause_end = 1'b1;
                    em_next = EM_IDLE;
                    len_next = '0;
                    sat_next = 1'b0;
                    bad_next = 1'b0;
                    ctl.clear = 1'b1;
                end
                EM_BODY:
                begin
                    if (cuts_reg != '0)
                    begin
                        ow_next.is_added_clause = 1'b1;
                        case (ph_reg)
                            PH_NEG_B:
                            begin
                                ow_next.out_literal = -b_lit;
                                ph_next = PH_D_FIRST;
                            end
                            PH_D_FIRST:
                            begin
                                ow_next.out_literal = d_reg;
                                ow_next.clause_end = 1'b1;
                                ph_next = PH_NEG_A;
                            end
                            PH_NEG_A:
                            begin
                                ow_next.out_literal = -a_lit;
                                ph_next = PH_D_SECOND;
                            end
                            PH_D_SECOND:
                            begin
                                ow_next.out_literal = d_reg;
                                ow_next.clause_end = 1'b1;
                                ph_next = PH_A;
                            end
                            PH_A:
                            begin
                                ow_next.out_literal = a_lit;
                                ph_next = PH_B;
                            end
                            PH_B:
                            begin
                                ow_next.out_literal = b_lit;
                                ph_next = PH_NEG_D;
                            end
                            PH_NEG_D:
                            begin
                                ow_next.out_literal = -d_reg;
                                ow_next.clause_end = 1'b1;
                                ph_next = PH_NEG_B;
                                cuts_next = cuts_reg - LenW'(1);
                                n_next = n_reg - LenW'(1);
                                d_next = d_reg + LitW'(1);
                                ctl.load = 1'b1;
                                ctl.lit = d_reg;
                                ld_idx = n_reg - LenW'(2);
                            end
                            default:
                            begin
                                ph_next = PH_NEG_B;
                            end
                        endcase
                    end
                    else
                    begin
                        ow_next.out_literal = cl[0];
                        ow_next.clause_end = (n_reg == LenW'(1));
                        ctl.shift = 1'b1;
                        n_next = n_reg - LenW'(1);
                        if (n_reg == LenW'(1))
                        begin
                            em_next = EM_IDLE;
                            len_next = '0;
                            sat_next = 1'b0;
                            bad_next = 1'b0;
                            ctl.clear = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg <= 13'd1;
            split_reg <= 1'b0;
            len_reg <= '0;
            sat_reg <= 1'b0;
            bad_reg <= 1'b0;
            dup_reg <= '0;
            taut_reg <= '0;
            unit_reg <= '0;
            add_reg <= '0;
            maxl_reg <= '0;
            fresh_reg <= '0;
            em_reg <= EM_IDLE;
            ph_reg <= PH_NEG_B;
            n_reg <= '0;
            cuts_reg <= '0;
            d_reg <= '0;
            ow_reg <= '0;
            ow_valid_reg <= 1'b0;
        end
        else
        begin
            dv_reg <= dv_next;
            split_reg <= split_next;
            len_reg <= len_next;
            sat_reg <= sat_next;
            bad_reg <= bad_next;
            dup_reg <= dup_next;
            taut_reg <= taut_next;
            unit_reg <= unit_next;
            add_reg <= add_next;
            maxl_reg <= maxl_next;
            fresh_reg <= fresh_next;
            em_reg <= em_next;
            ph_reg <= ph_next;
            n_reg <= n_next;
            cuts_reg <= cuts_next;
            d_reg <= d_next;
            ow_reg <= ow_next;
            ow_valid_reg <= ow_valid_next;
        end
    end

    assign out_valid = ow_valid_reg;
    assign out_data = ow_reg;
endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the clause normalize and split unit. Clauses of
// signed literals go in with random gaps and random output stalls; a model
// of the block predicts every emitted word, which is checked field by field.
// ----------------------------------------------------------------------------
module testbench import ccns_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    in_word_t    in_data;
    logic        in_valid;
    logic        in_stall;
    out_word_t   out_data;
    logic        out_valid;
    logic        out_stall;
    logic        cfg_we;
    logic        cfg_index;
    logic [12:0] cfg_data;

    cnf_clause_normalize_split_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Model state.
    int unsigned m_vars;
    bit          m_split;
    bit          m_marks [2*MaxVars+1];
    int          m_buf [MaxClauseLits];
    int unsigned m_len;
    bit          m_sat;
    bit          m_bad;
    logic [31:0] m_dup;
    logic [31:0] m_taut;
    logic [31:0] m_unit;
    logic [3:0]  m_longest;
    logic [19:0] m_fresh;
    logic [31:0] m_added;

    in_word_t  literal_queue [$];
    out_word_t expected_words [$];
    int        errors = 0;

    function automatic logic [31:0] sat_add(logic [31:0] v, int unsigned by);
        longint unsigned s;
        s = longint'(v) + by;
        return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void model_reset();
        m_vars = 1;
        m_split = 0;
        foreach (m_marks[i]) m_marks[i] = 0;
        m_len = 0;
        m_sat = 0;
        m_bad = 0;
        m_dup = 0;
        m_taut = 0;
        m_unit = 0;
        m_longest = 0;
        m_fresh = 0;
        m_added = 0;
    endfunction

    function automatic void predict_clause_words(in_word_t w);
        int          lit;
        int unsigned absv;
        int unsigned n;
        int unsigned cuts;
        int          work [MaxClauseLits];
        int          a;
        int          b;
        int          d;
        out_word_t   pend [$];
        out_word_t   o;
        lit = int'(w.literal);
        if (!m_bad) begin
            absv = (lit < 0) ? -lit : lit;
            if (lit == 0 || absv > m_vars || absv > MaxVars) begin
                m_bad = 1;
            end
            else if (m_marks[lit + MaxVars]) begin
                m_dup = sat_add(m_dup, 1);
            end
            else if (m_marks[-lit + MaxVars]) begin
                m_sat = 1;
            end
            else if (m_len >= MaxClauseLits) begin
                m_bad = 1;
            end
            else begin
                m_marks[lit + MaxVars] = 1;
                m_buf[m_len] = lit;
                m_len++;
            end
        end
        if (!w.last_in_clause) return;
        o = '0;
        if (m_bad) begin
            o.clause_end = 1;
            o.error = 1;
            pend.push_back(o);
        end
        else if (m_sat) begin
            m_taut = sat_add(m_taut, 1);
        end
        else if (m_len > 0) begin
            n = m_len;
            cuts = (m_split && n > SplitWidth) ? n - SplitWidth : 0;
            if (longint'(m_vars) + m_fresh + cuts > 1048575) begin
                o.clause_end = 1;
                o.error = 1;
                pend.push_back(o);
            end
            else begin
                work = m_buf;
                if (n > m_longest) m_longest = 4'(n);
                if (n == 1) m_unit = sat_add(m_unit, 1);
                while (cuts > 0) begin
                    b = work[n-1];
                    a = work[n-2];
                    m_fresh++;
                    d = m_vars + m_fresh;
                    o = '0;
                    o.is_added_clause = 1;
                    o.out_literal = LitW'(-b); o.clause_end = 0; pend.push_back(o);
                    o.out_literal = LitW'(d);  o.clause_end = 1; pend.push_back(o);
                    o.out_literal = LitW'(-a); o.clause_end = 0; pend.push_back(o);
                    o.out_literal = LitW'(d);  o.clause_end = 1; pend.push_back(o);
                    o.out_literal = LitW'(a);  o.clause_end = 0; pend.push_back(o);
                    o.out_literal = LitW'(b);  o.clause_end = 0; pend.push_back(o);
                    o.out_literal = LitW'(-d); o.clause_end = 1; pend.push_back(o);
                    m_added = sat_add(m_added, 3);
                    work[n-2] = d;
                    n--;
                    cuts--;
                end
                for (int i = 0; i < n; i++) begin
                    o = '0;
                    o.out_literal = LitW'(work[i]);
                    o.clause_end = (i == n - 1);
                    pend.push_back(o);
                end
            end
        end
        for (int i = 0; i < m_len; i++) m_marks[m_buf[i] + MaxVars] = 0;
        m_len = 0;
        m_sat = 0;
        m_bad = 0;
        foreach (pend[i]) begin
            pend[i].duplicate_count = m_dup;
            pend[i].tautology_count = m_taut;
            pend[i].unit_count = m_unit;
            pend[i].longest_clause = m_longest;
            pend[i].fresh_var_count = m_fresh;
            pend[i].added_clause_count = m_added;
            expected_words.push_back(pend[i]);
        end
    endfunction

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Driver.
    int in_gap = 0;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 0;
            in_data <= '0;
            in_gap = 0;
        end
        else begin
            if (in_valid && !in_stall) begin
                predict_clause_words(in_data);
                in_gap = $urandom_range(0, 5);
                if ($urandom_range(0, 3) == 0) in_gap = 0;
            end
            if (!in_valid || !in_stall) begin
                if (in_gap > 0 || literal_queue.size() == 0) begin
                    if (in_gap > 0) in_gap--;
                    in_valid <= 0;
                end
                else begin
                    in_valid <= 1;
                    in_data <= literal_queue.pop_front();
                end
            end
        end
    end

    // Monitor.
    int out_wait = 0;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 0;
            out_wait = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word, literal %0d", out_data.out_literal);
                    errors++;
                end
                else begin
                    out_word_t e;
                    e = expected_words.pop_front();
                    if (out_data.out_literal !== e.out_literal) begin
                        $error("out_literal exp %0d got %0d", e.out_literal,
                               out_data.out_literal);
                        errors++;
                    end
                    if (out_data.clause_end !== e.clause_end) begin
                        $error("clause_end exp %0d got %0d", e.clause_end,
                               out_data.clause_end);
                        errors++;
                    end
                    if (out_data.is_added_clause !== e.is_added_clause) begin
                        $error("is_added_clause exp %0d got %0d", e.is_added_clause,
                               out_data.is_added_clause);
                        errors++;
                    end
                    if (out_data.error !== e.error) begin
                        $error("error exp %0d got %0d", e.error, out_data.error);
                        errors++;
                    end
                    if (out_data.duplicate_count !== e.duplicate_count) begin
                        $error("duplicate_count exp %0d got %0d", e.duplicate_count,
                               out_data.duplicate_count);
                        errors++;
                    end
                    if (out_data.tautology_count !== e.tautology_count) begin
                        $error("tautology_count exp %0d got %0d", e.tautology_count,
                               out_data.tautology_count);
                        errors++;
                    end
                    if (out_data.unit_count !== e.unit_count) begin
                        $error("unit_count exp %0d got %0d", e.unit_count,
                               out_data.unit_count);
                        errors++;
                    end
                    if (out_data.longest_clause !== e.longest_clause) begin
                        $error("longest_clause exp %0d got %0d", e.longest_clause,
                               out_data.longest_clause);
                        errors++;
                    end
                    if (out_data.fresh_var_count !== e.fresh_var_count) begin
                        $error("fresh_var_count exp %0d got %0d", e.fresh_var_count,
                               out_data.fresh_var_count);
                        errors++;
                    end
                    if (out_data.added_clause_count !== e.added_clause_count) begin
                        $error("added_clause_count exp %0d got %0d",
                               e.added_clause_count, out_data.added_clause_count);
                        errors++;
                    end
                end
                out_wait = $urandom_range(0, 5);
                if ($urandom_range(0, 3) == 0) out_wait = 0;
            end
            if (out_wait > 0) begin
                out_wait--;
                out_stall <= 1;
            end
            else begin
                out_stall <= 0;
            end
        end
    end

    function automatic void push_lit(int lit, bit last);
        in_word_t w;
        w.literal = 14'(lit);
        w.last_in_clause = last;
        literal_queue.push_back(w);
    endfunction

    // Random clause over variables 1..span with occasional repeats,
    // complements and bad literals.
    function automatic void push_random_clause(int span);
        int len;
        int lit;
        int kind;
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
            kind = $urandom_range(0, 19);
            if (kind == 0) lit = 0;
            else if (kind == 1) lit = $urandom_range(0, 16383);
            else lit = $urandom_range(1, span);
            if (lit > 8191) lit = lit - 16384;
            else if (kind > 1 && $urandom_range(0, 1)) lit = -lit;
            push_lit(lit, i == len - 1);
        end
    endfunction

    task automatic write_reg(logic idx, logic [12:0] val);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        if (idx == CFG_DECLARED_VARS) m_vars = val;
        else m_split = val[0];
    endtask

    task automatic drain_phase();
        while (literal_queue.size() != 0 || in_valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial begin
        int spans [4];
        int limits [4];
        bit splits [4];
        spans = '{4, 12, 40, 4096};
        limits = '{4, 12, 8191, 4096};
        splits = '{1, 0, 1, 1};
        clk = 0;
        rst_n = 1;
        in_valid = 0;
        in_data = '0;
        out_stall = 0;
        cfg_we = 0;
        cfg_index = CFG_DECLARED_VARS;
        cfg_data = '0;
        model_reset();
        #1 rst_n = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        // Directed clauses with the reset settings, then split mode.
        push_lit(1, 1);
        push_lit(-1, 0); push_lit(-1, 1);
        push_lit(2, 1);
        push_lit(0, 0); push_lit(1, 1);
        drain_phase();
        write_reg(CFG_DECLARED_VARS, 13'd4096);
        write_reg(CFG_SPLIT, 13'd1);
        push_lit(4096, 0); push_lit(-4096, 0); push_lit(4096, 1);
        push_lit(8191, 0); push_lit(-8192, 1);
        push_lit(4097, 1);
        for (int i = 1; i <= 8; i++) push_lit(i * 500 - ((i % 2) ? 2 * i * 500 : 0), i == 8);
        for (int i = 1; i <= 9; i++) push_lit(i, i == 9);
        push_lit(5, 0); push_lit(-7, 0); push_lit(5, 0); push_lit(9, 1);
        drain_phase();
        write_reg(CFG_DECLARED_VARS, 13'd8191);
        for (int i = 1; i <= 5; i++) push_lit(i + 100, i == 5);
        drain_phase();
        for (int p = 0; p < 4; p++) begin
            write_reg(CFG_DECLARED_VARS, 13'(limits[p]));
            write_reg(CFG_SPLIT, 13'(splits[p]));
            while (literal_queue.size() < 62) push_random_clause(spans[p]);
            drain_phase();
        end
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #3ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
